### hdl/trial_division_factorizer_assert.svh
// Assertion macros shared by the factorizer RTL.
// Both macros sample on the rising edge of clk and are off while rst is high.
`ifndef TRIAL_DIVISION_FACTORIZER_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define TDF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TDF_ASSERT_SAME(lbl, ante, cons)
`define TDF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/tdf_pkg.sv
package tdf_pkg;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

  // Field widths
  localparam int IN_W     = 32;
  localparam int FACTOR_W = 32;
  localparam int CAP_W    = 6;
  localparam int POS_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
  // Most results one value may produce
  localparam logic [POS_W-1:0] MAX_RES   = 5'd31;

endpackage

### hdl/trial_division_factorizer.sv
// The single restoring divider tests one trial divisor at a time, so an item's run time
// grows with the number of trial divisors it needs.
// Values 0 and 1 skip the divider; a result waits in the output register while the sink stalls.
// Throughput: one item at a time; in_stall stays high until its last result is loaded.
// Reset (synchronous, rst high): capacity returns to 32, the sequencer goes idle,
// any pending results are dropped.
`include "trial_division_factorizer_assert.svh"

module trial_division_factorizer #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdf_pkg::ADDR_W-1:0]    paddr,
  input  logic [tdf_pkg::DATA_W-1:0]    pwdata,
  output logic [tdf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tdf_pkg::IN_W-1:0]      value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tdf_pkg::FACTOR_W-1:0]  factor,
  output logic                          has_factor,
  output logic                          kept,
  output logic [tdf_pkg::POS_W-1:0]     position,
  output logic [tdf_pkg::POS_W-1:0]     total_count,
  output logic                          last
);

  localparam int VW = VALUE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NONE,
    S_START,
    S_WAIT,
    S_EVAL,
    S_LEFT,
    S_LAST
  } state_t;

  state_t                      state;
  logic [VW-1:0]               v;
  logic [VW-1:0]               d;
  logic [tdf_pkg::POS_W-1:0]   n;
  logic [VW-1:0]               pend;
  logic [tdf_pkg::POS_W-1:0]   pend_pos;
  logic                        has_pend;
  logic [tdf_pkg::CAP_W-1:0]   capacity;

  logic                        div_done;
  logic [VW-1:0]               div_quo;
  logic [VW-1:0]               div_rem;

  logic [VW-1:0]               v_in;
  logic                        out_free;
  logic                        q_ge_d;
  logic                        found;
  logic                        push;
  logic                        push_last;
  logic                        push_none;
  logic                        o_kept;

  tdf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  tdf_div #(.W(VW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_START),
    .dividend  (v),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign v_in     = VW'(value);
  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  // Trial continues while d <= v / d; a zero remainder is a factor
  assign q_ge_d = div_quo >= d;
  assign found  = q_ge_d && (div_rem == '0);

  // Decide when the pending factor moves into the output register
  always_comb begin
    push      = 1'b0;
    push_last = 1'b0;
    push_none = 1'b0;
    case (state)
      S_NONE: begin
        push      = out_free;
        push_last = 1'b1;
        push_none = 1'b1;
      end
      S_EVAL: push = found && has_pend && out_free;
      S_LEFT: push = has_pend && out_free;
      S_LAST: begin
        push      = out_free;
        push_last = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign o_kept = !push_none && ({1'b0, pend_pos} < capacity);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      has_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Load a result, or drop the one just transferred
      if (push) begin
        out_valid   <= 1'b1;
        has_factor  <= !push_none;
        kept        <= o_kept;
        factor      <= o_kept ? tdf_pkg::FACTOR_W'(pend) : '0;
        position    <= push_none ? '0 : pend_pos;
        total_count <= push_last ? n : '0;
        last        <= push_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            v        <= v_in;
            d        <= VW'(2);
            n        <= '0;
            has_pend <= 1'b0;
            state    <= (v_in <= VW'(1)) ? S_NONE : S_START;
          end
        end
        S_NONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!q_ge_d) begin
            state <= S_LEFT;
          end else if (found) begin
            if (!has_pend || out_free) begin
              pend     <= d;
              pend_pos <= n;
              has_pend <= 1'b1;
              n        <= n + tdf_pkg::POS_W'(1);
              v        <= div_quo;
              if (n == tdf_pkg::MAX_RES - tdf_pkg::POS_W'(1) || div_quo == VW'(1)) begin
                state <= S_LAST;
              end else begin
                state <= S_START;
              end
            end
          end else begin
            // Advance to the next candidate: 2, 3, 5, 7, ...
            d     <= (d == VW'(2)) ? VW'(3) : d + VW'(2);
            state <= S_START;
          end
        end
        S_LEFT: begin
          // Remaining value above one is the largest prime factor
          if (!has_pend || out_free) begin
            pend     <= v;
            pend_pos <= n;
            has_pend <= 1'b1;
            n        <= n + tdf_pkg::POS_W'(1);
            state    <= S_LAST;
          end
        end
        S_LAST: begin
          if (out_free) begin
            has_pend <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TDF_ASSERT_SAME(a_none_is_single, out_valid && !has_factor, last && position == '0 && factor == '0)
  `TDF_ASSERT_SAME(a_count_on_last, out_valid && !last, total_count == '0)
  `TDF_ASSERT_SAME(a_dropped_is_zero, out_valid && has_factor && !kept, factor == '0)
  `TDF_ASSERT_NEXT(a_div_only_waiting, div_done, state == S_EVAL)
  `TDF_ASSERT_SAME(a_push_has_pend, push && !push_none, has_pend)

endmodule

### hdl/tdf_div.sv
module tdf_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign shifted = {rem, quo[W-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // Flag completion once the final step has been taken
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? diff[W-1:0] : shifted[W-1:0];
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hdl/tdf_cfg.sv
module tdf_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tdf_pkg::ADDR_W-1:0]  paddr,
  input  logic [tdf_pkg::DATA_W-1:0]  pwdata,
  output logic [tdf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [tdf_pkg::CAP_W-1:0]   capacity
);

  logic hit;

  // Decode the word address
  assign hit    = paddr[tdf_pkg::ADDR_W-1:2] == tdf_pkg::REG_CAPACITY;
  assign pready = 1'b1;

  // Capture a write at the end of the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= tdf_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && hit) begin
      capacity <= pwdata[tdf_pkg::CAP_W-1:0];
    end
  end

  assign prdata = hit ? tdf_pkg::DATA_W'(capacity) : '0;

endmodule

### tb/tb_trial_division_factorizer.sv
`timescale 1ns / 1ps

module tb_trial_division_factorizer;

  localparam int REPORT_LIMIT = 10;
  localparam int QUIET_LIMIT  = 200000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 14;
  localparam logic [tdf_pkg::ADDR_W-1:0] CAPACITY_ADDR = {tdf_pkg::REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic [tdf_pkg::FACTOR_W-1:0] factor;
    logic                         has_factor;
    logic                         kept;
    logic [tdf_pkg::POS_W-1:0]    position;
    logic [tdf_pkg::POS_W-1:0]    total_count;
    logic                         last;
  } factor_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_t;

  // Expected factor lists, worked out per accepted value
  class factor_ledger;
    logic [tdf_pkg::CAP_W-1:0] capacity;
    factor_result_t            pending[$];
    int                        errors;
    int                        values_in;
    int                        results_out;

    function new();
      capacity    = tdf_pkg::CAP_RESET;
      errors      = 0;
      values_in   = 0;
      results_out = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
    endfunction

    function string show(factor_result_t r);
      return $sformatf("factor=%0d has_factor=%0b kept=%0b position=%0d total_count=%0d last=%0b",
                       r.factor, r.has_factor, r.kept, r.position, r.total_count, r.last);
    endfunction

    // Divide out 2, then odd trial divisors, while divisor squared fits the rest
    function void add_value(logic [tdf_pkg::IN_W-1:0] raw);
      longint unsigned rest;
      longint unsigned d;
      longint unsigned f;
      longint unsigned found[$];
      int unsigned     idx;
      int unsigned     n;
      factor_result_t  r;
      rest = raw;
      d    = 2;
      values_in++;
      if (rest <= 1) begin
        r      = '0;
        r.last = 1'b1;
        pending.push_back(r);
        return;
      end
      while (rest > 1 && d <= rest / d && found.size() < tdf_pkg::MAX_RES) begin
        while (rest % d == 0 && found.size() < tdf_pkg::MAX_RES) begin
          found.push_back(d);
          rest = rest / d;
        end
        d = (d == 2) ? 3 : d + 2;
      end
      // Leftover above one is itself prime
      if (rest > 1 && found.size() < tdf_pkg::MAX_RES) found.push_back(rest);
      n = found.size();
      for (idx = 0; idx < n; idx++) begin
        f             = found[idx];
        r.has_factor  = 1'b1;
        r.kept        = (idx < capacity);
        r.factor      = r.kept ? f[tdf_pkg::FACTOR_W-1:0] : '0;
        r.position    = idx[tdf_pkg::POS_W-1:0];
        r.last        = (idx == n - 1);
        r.total_count = r.last ? n[tdf_pkg::POS_W-1:0] : '0;
        pending.push_back(r);
      end
    endfunction

    function void check_result(factor_result_t got);
      factor_result_t want;
      results_out++;
      if (pending.size() == 0) begin
        flag($sformatf("result with nothing pending: %s", show(got)));
        return;
      end
      want = pending.pop_front();
      if (got.factor !== want.factor || got.has_factor !== want.has_factor ||
          got.kept !== want.kept || got.position !== want.position ||
          got.total_count !== want.total_count || got.last !== want.last)
        flag($sformatf("expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [tdf_pkg::ADDR_W-1:0]    paddr = '0;
  logic [tdf_pkg::DATA_W-1:0]    pwdata = '0;
  logic [tdf_pkg::DATA_W-1:0]    prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [tdf_pkg::IN_W-1:0]      value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [tdf_pkg::FACTOR_W-1:0]  factor;
  logic                          has_factor;
  logic                          kept;
  logic [tdf_pkg::POS_W-1:0]     position;
  logic [tdf_pkg::POS_W-1:0]     total_count;
  logic                          last;

  factor_ledger ledger;
  int           burst_left = 0;
  int           results_taken = 0;
  int           quiet_cycles = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  int           mode_left = 0;
  stall_mode_t  stall_mode = STALL_NONE;

  // Primes, prime powers, squares, 31 factors and all-ones patterns
  logic [tdf_pkg::IN_W-1:0] corner_values[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd25, 32'd66049, 32'd30030,
    32'd65537, 32'd1000003, 32'h8000_0000, 32'hC000_0000, 32'd3486784401,
    32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFF1_0000
  };

  // Low six bits give 0, 63, 1, 30, 32; the rest exercise the unused data bits
  logic [tdf_pkg::DATA_W-1:0] capacity_words[PHASES] = '{
    32'h0000_0000, 32'h0000_003F, 32'hA5A5_0001, 32'd30, 32'hFFFF_FFE0, 32'h0
  };

  trial_division_factorizer u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .factor      (factor),
    .has_factor  (has_factor),
    .kept        (kept),
    .position    (position),
    .total_count (total_count),
    .last        (last)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned small_prime(int unsigned idx);
    case (idx)
      0: return 2;
      1: return 3;
      2: return 5;
      3: return 7;
      4: return 11;
      5: return 13;
      6: return 17;
      7: return 19;
      8: return 23;
      9: return 29;
      10: return 31;
      default: return 37;
    endcase
  endfunction

  // Small cofactor times small primes, or a masked random value: short search
  function automatic logic [tdf_pkg::IN_W-1:0] random_value();
    longint unsigned v;
    longint unsigned p;
    bit              done;
    int              i;
    logic [31:0]     mask;
    if ($urandom_range(0, 9) == 0) begin
      mask = (32'd1 << $urandom_range(1, 18)) - 32'd1;
      return $urandom & mask;
    end
    v    = $urandom_range(1, 65536);
    done = 1'b0;
    for (i = 0; i < 40 && !done; i++) begin
      p = small_prime(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      if (v * p > 64'hFFFF_FFFF || $urandom_range(0, 15) == 0) done = 1'b1;
      else v = v * p;
    end
    return v[tdf_pkg::IN_W-1:0];
  endfunction

  // Offer one value in bursts with random gaps; record it on transfer
  task automatic send_value(logic [tdf_pkg::IN_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.add_value(v);
  endtask

  // Hold off new values until every pending factor has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write capacity, then read it back
  task automatic set_capacity(logic [tdf_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ledger.capacity = data[tdf_pkg::CAP_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== tdf_pkg::DATA_W'(ledger.capacity))
      ledger.flag($sformatf("capacity readback expected %0d, got %0d", ledger.capacity, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Check each result transfer; stall in changing modes plus one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      ledger.check_result({factor, has_factor, kept, position, total_count, last});
      results_taken++;
    end
    if (!hold_done && results_taken >= 40 && in_valid) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        default:      out_stall <= ((mode_left % 8) < 5);
      endcase
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase;
    ledger = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Corner values at the reset capacity
    foreach (corner_values[i]) send_value(corner_values[i]);
    drain_results();

    // 2^31 and then random values under each capacity setting
    for (phase = 0; phase < PHASES; phase++) begin
      set_capacity((phase == PHASES - 1) ? $urandom : capacity_words[phase]);
      send_value(32'h8000_0000);
      repeat (PHASE_ITEMS) send_value(random_value());
      drain_results();
    end

    repeat (50) @(posedge clk);
    if (ledger.pending.size() != 0)
      ledger.flag($sformatf("%0d results never arrived", ledger.pending.size()));

    $display("Factored %0d values into %0d results under capacities 32, 0, 63, 1, 30, 32",
             ledger.values_in, ledger.results_out);
    $display("and one random setting, with a long sink hold-off and bursty traffic.");
    if (ledger.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", ledger.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/tdf_pkg.sv
hdl/tdf_div.sv
hdl/tdf_cfg.sv
hdl/trial_division_factorizer.sv
tb/tb_trial_division_factorizer.sv
